>>> hdl/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg - occupancy grid cell update, shared definitions
// Command codes, register indexes, register reset values and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package occ_pkg;

	// fraction bits of a probability, 1.0 = 2^PROB_BITS
	localparam int PROB_BITS = 16;
	localparam int PROB_W    = 16;

	localparam int GRID_COLS_DEF = 256;
	localparam int GRID_ROWS_DEF = 256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_P_HIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_P_MISS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_P_MIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_P_MAX  = 2'd3;

	localparam logic [PROB_W-1:0] P_HIT_RST  = 16'd36045;
	localparam logic [PROB_W-1:0] P_MISS_RST = 16'd32113;
	localparam logic [PROB_W-1:0] P_MIN_RST  = 16'd6554;
	localparam logic [PROB_W-1:0] P_MAX_RST  = 16'd58982;

	localparam logic [1:0] CMD_MISS = 2'd0;
	localparam logic [1:0] CMD_HIT  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] cell_u;
		logic [7:0] cell_v;
		logic       first_scan;
	} occ_item_t;

	typedef struct packed {
		logic [PROB_W-1:0] cell_value;
		logic              cell_known;
	} occ_result_t;

endpackage

`default_nettype wire

>>> hdl/occ_ram.sv
// ----------------------------------------------------------------------------
// occ_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/occupancy_grid_cell_update_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_cell_update_top - Bayesian occupancy grid cell update
// Per-cell probability store with odds-product update, clamping and read-out.
// ----------------------------------------------------------------------------
//
//  channel   | signals                        | transfer
//  ----------+--------------------------------+---------------------------------
//  command   | start, busy, item              | start && !busy at a rising edge
//  result    | done, result                   | done high for one cycle, no stall
//  config    | cfg_we, cfg_index, cfg_data    | cfg_we at a rising edge
//
//  Sequence: an out-of-range cell answers from idle with a registered done; a read,
//  a first write or a first-scan write of a cell passes through the decide state;
//  an odds update of a known cell runs decide, two shared multiplies, sum, prep,
//  the radix-2 divider (PROB_W+1 quotient bits, one per cycle) and clamp.
//  Reset: after arst_n rises the store is swept once, one entry per cycle, over
//  all GRID_COLS*GRID_ROWS entries (65536 by default), with busy high throughout;
//  configuration writes are taken during the sweep.
//  Results cannot be stalled; a new transaction is taken in the cycle done shows.
//
`default_nettype none

module occupancy_grid_cell_update_top
	import occ_pkg::*;
#(
	parameter int GRID_COLS = GRID_COLS_DEF,
	parameter int GRID_ROWS = GRID_ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire occ_item_t             item,
	output logic                       done,
	output occ_result_t                result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS  = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int WORD_W = PROB_W + 1;          // {known, probability}
	localparam int OP_W   = PROB_W + 1;          // multiplier operand, holds 1.0
	localparam int A_W    = 2 * PROB_W;          // m*P
	localparam int B_W    = 2 * PROB_W + 1;      // (1-m)(1-P), up to 1.0*1.0
	localparam int DEN_W  = 2 * PROB_W + 2;      // a+b
	localparam int NUM_W  = 3 * PROB_W + 1;      // a*2^PROB_BITS + den/2
	localparam int Q_W    = PROB_W + 1;          // quotient may reach 1.0
	localparam int CNT_W  = $clog2(Q_W);

	localparam logic [OP_W-1:0] ONE_FX = OP_W'(1) << PROB_BITS;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_CLAMP
	} state_t;

	state_t state_q;

	// configuration
	logic [PROB_W-1:0] p_hit_q, p_miss_q, p_min_q, p_max_q;

	// transaction context
	logic [1:0]        cmd_q;
	logic              first_q;
	logic [ADDR_W-1:0] idx_q;
	logic [PROB_W-1:0] m_q;

	// datapath
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   sh_q;    // numerator low bits in, quotient bits out
	logic [CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0] clr_q;

	logic        done_q;
	occ_result_t result_q;

	// store
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic              accept, in_range;
	logic [ADDR_W-1:0] idx_in;
	logic              rd_known;
	logic [PROB_W-1:0] rd_prob;
	logic              is_upd, direct_wr;
	logic [PROB_W-1:0] obs, first_val, direct_val, clamp_val;

	logic [OP_W-1:0]     mul_x, mul_y;
	logic [2*OP_W-1:0]   prod;
	logic [NUM_W-1:0]    num;
	logic [DEN_W:0]      trial;
	logic                trial_ge;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign in_range = (32'(item.cell_u) < GRID_COLS) && (32'(item.cell_v) < GRID_ROWS);
	assign idx_in   = ADDR_W'(32'(item.cell_v) * GRID_COLS + 32'(item.cell_u));

	assign rd_known = ram_rdata[WORD_W-1];
	assign rd_prob  = ram_rdata[PROB_W-1:0];

	always_comb begin
		case (cmd_q) inside
			CMD_MISS, CMD_HIT: is_upd = 1'b1;
			default:           is_upd = 1'b0;   // read, and the spare code
		endcase
	end

	assign obs        = (cmd_q == CMD_HIT) ? p_hit_q : p_miss_q;
	assign first_val  = (cmd_q == CMD_HIT) ? p_max_q : p_min_q;
	assign direct_wr  = is_upd && (first_q || !rd_known);
	assign direct_val = first_q ? first_val : obs;

	// shared multiplier: a = m*P, then b = (1-m)(1-P)
	always_comb begin
		if (state_q == ST_MUL_B) begin
			mul_x = ONE_FX - OP_W'(m_q);
			mul_y = ONE_FX - OP_W'(obs);
		end else begin
			mul_x = OP_W'(m_q);
			mul_y = OP_W'(obs);
		end
	end
	assign prod = mul_x * mul_y;

	// round to nearest, ties up: (a*2^PROB_BITS + den/2) / den
	assign num = (NUM_W'(a_q) << PROB_BITS) + NUM_W'(den_q >> 1);

	// one restoring division step
	assign trial    = {rem_q, sh_q[Q_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	// clamp, upper bound first
	always_comb begin
		if (sh_q > Q_W'(p_max_q)) begin
			clamp_val = p_max_q;
		end else if (sh_q < Q_W'(p_min_q)) begin
			clamp_val = p_min_q;
		end else begin
			clamp_val = sh_q[PROB_W-1:0];
		end
	end

	// store ports; a write always lands before the next read is issued, so
	// back-to-back transactions on one cell need no forwarding
	always_comb begin
		ram_re    = accept && in_range;
		ram_raddr = idx_in;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, direct_val};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_DECIDE: begin
				ram_we = direct_wr;
			end
			ST_CLAMP: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, clamp_val};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	occ_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_hit_q  <= P_HIT_RST;
			p_miss_q <= P_MISS_RST;
			p_min_q  <= P_MIN_RST;
			p_max_q  <= P_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_P_HIT:  p_hit_q  <= cfg_data;
				CFG_P_MISS: p_miss_q <= cfg_data;
				CFG_P_MIN:  p_min_q  <= cfg_data;
				CFG_P_MAX:  p_max_q  <= cfg_data;
				default:    p_hit_q  <= p_hit_q;
			endcase
		end
	end

	// sequencer, sweep counter, divider count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_range) begin
							state_q <= ST_DECIDE;
						end else begin
							done_q   <= 1'b1;
							result_q <= '0;
						end
					end
				end
				ST_DECIDE: begin
					if (!is_upd) begin
						state_q             <= ST_IDLE;
						done_q              <= 1'b1;
						result_q.cell_known <= rd_known;
						result_q.cell_value <= rd_known ? rd_prob : '0;
					end else if (direct_wr) begin
						state_q             <= ST_IDLE;
						done_q              <= 1'b1;
						result_q.cell_known <= 1'b1;
						result_q.cell_value <= direct_val;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(Q_W - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q             <= ST_IDLE;
					done_q              <= 1'b1;
					result_q.cell_known <= 1'b1;
					result_q.cell_value <= clamp_val;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= item.command;
			first_q <= item.first_scan;
			idx_q   <= idx_in;
		end
		if (state_q == ST_DECIDE) begin
			m_q <= rd_prob;
		end
		if (state_q == ST_MUL_A) begin
			a_q <= prod[A_W-1:0];
		end
		if (state_q == ST_MUL_B) begin
			b_q <= prod[B_W-1:0];
		end
		if (state_q == ST_SUM) begin
			den_q <= DEN_W'(a_q) + DEN_W'(b_q);
		end
		if (state_q == ST_PREP) begin
			// quotient stays below 2^Q_W, so the top bits start below den
			rem_q <= DEN_W'(num[NUM_W-1:Q_W]);
			sh_q  <= num[Q_W-1:0];
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], trial_ge};
		end
	end

endmodule

`default_nettype wire

>>> hdl/occ_checker.sv
// ----------------------------------------------------------------------------
// occ_checker - port-level checks for the occupancy grid cell update
// Transaction ordering and result consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_checker
	import occ_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire occ_result_t result,
	input wire logic        done
);

	// a result appears only once the block is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an unknown cell never reports a value
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.cell_known) |-> (result.cell_value == '0))
		else $error("unknown cell with nonzero value");

	// an accepted transaction either answers at once or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction vanished");

	// the block only goes busy on an accepted transaction
	a_no_spurious_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !busy)
		else $error("busy without a transaction");

	// no result without a transaction in flight
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result without a transaction");

endmodule

bind occupancy_grid_cell_update_top occ_checker u_occ_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.result(result),
	.done  (done)
);

`default_nettype wire
